// ----- hdl/adef_pkg.sv -----
package adef_pkg;

  localparam int unsigned ID_W    = 32;
  localparam int unsigned AGE_W   = 17;
  localparam int unsigned LIMIT_W = 16;

  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [AGE_W-1:0]  age;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic clear_wr;
    logic start;
    logic issue;
    logic commit;
  } ctrl_t;

  typedef struct packed {
    logic cnt_last;
    logic out_free;
  } stat_t;

endpackage

// ----- hdl/adef_ram.sv -----
module adef_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/adef_ctrl.sv -----
module adef_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  adef_pkg::stat_t stat_i,
  output adef_pkg::ctrl_t ctrl_o
);
  import adef_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_COMMIT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d         = state_q;
    ctrl_o          = '0;
    in_ready_o      = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        ctrl_o.clear_wr = 1'b1;
        if (stat_i.cnt_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.start = 1'b1;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctrl_o.issue = 1'b1;
        if (stat_i.cnt_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (stat_i.out_free) begin
          ctrl_o.commit = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hdl/adef_datapath.sv -----
module adef_datapath #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  adef_pkg::ctrl_t               ctrl_i,
  output adef_pkg::stat_t               stat_o,
  input  logic                          op_i,
  input  logic [adef_pkg::ID_W-1:0]     id_i,
  input  logic                          cfg_we_i,
  input  logic [adef_pkg::LIMIT_W-1:0]  cfg_limit_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_is_new_o,
  output logic                          out_table_full_o
);
  import adef_pkg::*;

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

  logic [LIMIT_W-1:0] limit_q;
  logic [AW-1:0]      cnt_q, cnt_d;
  logic               dvalid_q;
  logic [AW-1:0]      didx_q;
  logic               op_q;
  logic [ID_W-1:0]    key_q;
  logic               hit_q, hit_d;
  logic               free_q, free_d;
  logic [AW-1:0]      free_idx_q, free_idx_d;
  logic               out_valid_q, out_valid_d;
  logic               is_new_q, full_q;

  logic               we;
  logic [AW-1:0]      waddr;
  entry_t             wentry;
  entry_t             rentry;
  logic [ENTRY_W-1:0] rdata;
  logic [AGE_W-1:0]   age_inc;
  logic               keep;
  logic               res_new, res_full;

  adef_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wentry),
    .re_i    (ctrl_i.issue),
    .raddr_i (cnt_q),
    .rdata_o (rdata)
  );

  assign rentry = entry_t'(rdata);
  assign age_inc = (rentry.age == AGE_MAX) ? rentry.age : rentry.age + 1'b1;
  assign keep = (age_inc <= {{(AGE_W-LIMIT_W){1'b0}}, limit_q});

  assign stat_o.cnt_last = (cnt_q == LAST_IDX);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign res_new  = (op_q == OP_CHECK) && !hit_q;
  assign res_full = res_new && !free_q;

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.start) begin
      cnt_d = '0;
    end else if (ctrl_i.clear_wr || ctrl_i.issue) begin
      cnt_d = stat_o.cnt_last ? '0 : cnt_q + 1'b1;
    end
  end

  always_comb begin
    hit_d      = hit_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    if (ctrl_i.start) begin
      hit_d  = 1'b0;
      free_d = 1'b0;
    end else if (dvalid_q && (op_q == OP_CHECK)) begin
      if (rentry.valid) begin
        if (rentry.id == key_q) begin
          hit_d = 1'b1;
        end
      end else if (!free_q) begin
        free_d     = 1'b1;
        free_idx_d = didx_q;
      end
    end
  end

  // write port: clearing pass, new entry, tick writeback
  always_comb begin
    we     = 1'b0;
    waddr  = didx_q;
    wentry = '0;
    if (ctrl_i.clear_wr) begin
      we    = 1'b1;
      waddr = cnt_q;
    end else if (ctrl_i.commit) begin
      we           = res_new && free_q;
      waddr        = free_idx_q;
      wentry.valid = 1'b1;
      wentry.id    = key_q;
      wentry.age   = '0;
    end else if (dvalid_q && (op_q == OP_TICK) && rentry.valid) begin
      we           = 1'b1;
      waddr        = didx_q;
      wentry.valid = keep;
      wentry.id    = rentry.id;
      wentry.age   = age_inc;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_i.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= '0;
      cnt_q       <= '0;
      dvalid_q    <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_limit_i;
      end
      cnt_q       <= cnt_d;
      dvalid_q    <= ctrl_i.issue;
      hit_q       <= hit_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    didx_q     <= cnt_q;
    free_idx_q <= free_idx_d;
    if (ctrl_i.start) begin
      op_q  <= op_i;
      key_q <= id_i;
    end
    if (ctrl_i.commit) begin
      is_new_q <= res_new;
      full_q   <= res_full;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_is_new_o     = is_new_q;
  assign out_table_full_o = full_q;

endmodule

// ----- hdl/aging_duplicate_event_filter.sv -----
// channel   direction  payload
// s_axis    in         tdata: event_identifier[31:0]; tuser: operation
// m_axis    out        tdata: is_new, table_full, zero fill to 8 bits
// cfg       in         data: record_time_limit[15:0]
//
// after reset a clearing pass writes every table entry before s_axis_tready rises
// each item is accepted, then read out one table entry at a time through the ram port,
// then passes drain and commit; a new item is taken only once commit is done
// the result sits in an output register; a stalled m_axis holds the next item in commit
// configuration writes are taken every cycle
module aging_duplicate_event_filter #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // event_identifier
  input  logic [0:0]  s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // is_new, table_full, zero fill
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);
  import adef_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic  is_new, table_full;

  assign cfg_ready_o = 1'b1;

  adef_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  adef_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .op_i             (s_axis_tuser[0]),
    .id_i             (s_axis_tdata),
    .cfg_we_i         (cfg_valid_i),
    .cfg_limit_i      (cfg_data_i),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_is_new_o     (is_new),
    .out_table_full_o (table_full)
  );

  assign m_axis_tdata = {6'b0, table_full, is_new};

endmodule

// ----- hdl/adef_checker.sv -----
module adef_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_full_is_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] || !m_axis_tdata[1]))
    else $error("table_full without is_new");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while busy");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without scan");

endmodule

bind aging_duplicate_event_filter adef_checker u_adef_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
